// File: hw/rtl/rcm_pkg.sv
package rcm_pkg;

    localparam int unsigned DATA_W     = 8;
    localparam int unsigned EXP_W      = 16;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    localparam logic [DATA_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [DATA_W-1:0] CHAR_OFFSET = 8'd64;

    localparam logic [DATA_W-1:0] MODULUS_RESET = 8'd35;
    localparam logic [EXP_W-1:0]  EXP_RESET     = 16'd5;

    // base-4 digits of an 8-bit multiplier operand
    localparam int unsigned MM_DIGITS = DATA_W / 2;
    localparam int unsigned MM_CNT_W  = $clog2(MM_DIGITS);
    // largest multiple of the modulus subtracted after one base-4 step
    localparam int unsigned MM_KMAX   = 6;
    localparam int unsigned MM_ACC_W  = DATA_W + 3;

    typedef enum logic [1:0] {
        REG_MODULUS = 2'd0,
        REG_ENC_EXP = 2'd1,
        REG_DEC_EXP = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        MM_BASE = 2'd0,
        MM_SQR  = 2'd1,
        MM_MUL  = 2'd2
    } mm_op_t;

    typedef struct packed {
        logic   load;
        logic   mm_start;
        mm_op_t mm_op;
        logic   advance;
        logic   publish;
    } cmd_t;

    typedef struct packed {
        logic mm_busy;
        logic exp_bit;
        logic bit_last;
        logic started;
        logic invalid;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/rcm_ctrl.sv
module rcm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output rcm_pkg::cmd_t cmd,
    input  rcm_pkg::sts_t sts
);
    import rcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_BASE_WAIT,
        S_BIT,
        S_SQR_WAIT,
        S_MUL_WAIT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mm_op  = MM_BASE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                if (sts.invalid)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_BASE;
                    state_next   = S_BASE_WAIT;
                end
            end
            S_BASE_WAIT:
            begin
                if (!sts.mm_busy)
                begin
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                // before the first set bit the accumulator is 1, so squaring is skipped
                if (sts.started)
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_SQR;
                    state_next   = S_SQR_WAIT;
                end
                else if (sts.exp_bit)
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_MUL;
                    state_next   = S_MUL_WAIT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = sts.bit_last ? S_FIN : S_BIT;
                end
            end
            S_SQR_WAIT:
            begin
                if (!sts.mm_busy)
                begin
                    if (sts.exp_bit)
                    begin
                        cmd.mm_start = 1'b1;
                        cmd.mm_op    = MM_MUL;
                        state_next   = S_MUL_WAIT;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = sts.bit_last ? S_FIN : S_BIT;
                    end
                end
            end
            S_MUL_WAIT:
            begin
                if (!sts.mm_busy)
                begin
                    cmd.advance = 1'b1;
                    state_next  = sts.bit_last ? S_FIN : S_BIT;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/rcm_datapath.sv
module rcm_datapath #(
    parameter int EXP_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rcm_pkg::cmd_t                  cmd,
    output rcm_pkg::sts_t                  sts,
    input  logic                           mode,
    input  logic [rcm_pkg::DATA_W-1:0]     char_in,
    input  logic [rcm_pkg::DATA_W-1:0]     modulus,
    input  logic [rcm_pkg::EXP_W-1:0]      encrypt_exponent,
    input  logic [rcm_pkg::EXP_W-1:0]      decrypt_exponent,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rcm_pkg::DATA_W-1:0]     char_out,
    output logic                           invalid
);
    import rcm_pkg::*;

    localparam int CNT_W = $clog2(EXP_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(EXP_BITS - 1);
    localparam logic [MM_CNT_W-1:0] MM_LAST = MM_CNT_W'(MM_DIGITS - 1);

    // item registers
    logic [DATA_W-1:0]   char_reg;
    logic                invalid_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DATA_W-1:0]   acc_reg;
    logic [DATA_W-1:0]   base_reg;
    logic                started_reg;

    // modular multiplier
    logic [DATA_W-1:0]   mm_a_reg;
    logic [DATA_W-1:0]   mm_b_reg;
    logic [DATA_W-1:0]   mm_x_reg;
    logic [MM_CNT_W-1:0] mm_cnt_reg;
    logic                mm_busy_reg;
    mm_op_t              mm_op_reg;

    // output register
    logic                out_valid_reg;
    logic [DATA_W-1:0]   char_out_reg;
    logic                invalid_out_reg;

    logic                  inv_in;
    logic [DATA_W-1:0]     v_in;
    logic [EXP_W-1:0]      exp_in;
    logic [EXP_BITS+EXP_W-1:0] exp_wide;
    logic [MM_ACC_W-1:0]   n_ext;
    logic [MM_ACC_W-1:0]   nmul [1:MM_KMAX];
    logic [MM_ACC_W-1:0]   da;
    logic [MM_ACC_W-1:0]   mm_sum;
    logic [MM_ACC_W-1:0]   mm_red;
    logic [DATA_W-1:0]     mm_res;
    logic [DATA_W-1:0]     r_final;
    logic [DATA_W-1:0]     char_out_next;

    assign inv_in   = (char_in < CHAR_OFFSET) && (char_in != CHAR_SPACE);
    assign v_in     = (char_in == CHAR_SPACE) ? '0 : char_in - CHAR_OFFSET;
    assign exp_in   = mode ? decrypt_exponent : encrypt_exponent;
    assign exp_wide = {{EXP_BITS{1'b0}}, exp_in};

    // one base-4 step of interleaved multiply and reduce: x = 4x + d*a, then mod n
    assign n_ext = {{(MM_ACC_W-DATA_W){1'b0}}, modulus};

    always_comb
    begin
        for (int k = 1; k <= MM_KMAX; k++)
        begin
            nmul[k] = MM_ACC_W'(n_ext * MM_ACC_W'(k));
        end
    end

    always_comb
    begin
        case (mm_b_reg[DATA_W-1 -: 2])
            2'd0:    da = '0;
            2'd1:    da = {3'b000, mm_a_reg};
            2'd2:    da = {2'b00, mm_a_reg, 1'b0};
            2'd3:    da = {3'b000, mm_a_reg} + {2'b00, mm_a_reg, 1'b0};
            default: da = '0;
        endcase
    end

    assign mm_sum = {1'b0, mm_x_reg, 2'b00} + da;

    always_comb
    begin
        mm_red = mm_sum;
        for (int k = 1; k <= MM_KMAX; k++)
        begin
            if (mm_sum >= nmul[k])
            begin
                mm_red = mm_sum - nmul[k];
            end
        end
    end

    assign mm_res = mm_red[DATA_W-1:0];

    // a modulus of zero or one makes every residue zero
    assign r_final = (modulus < 8'd2) ? '0 : acc_reg;

    always_comb
    begin
        if (invalid_reg)
        begin
            char_out_next = char_reg;
        end
        else if (r_final == '0)
        begin
            char_out_next = CHAR_SPACE;
        end
        else
        begin
            char_out_next = r_final + CHAR_OFFSET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_busy_reg   <= 1'b0;
            mm_cnt_reg    <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                started_reg <= 1'b0;
            end
            if (cmd.mm_start)
            begin
                mm_busy_reg <= 1'b1;
                mm_cnt_reg  <= '0;
                if (cmd.mm_op == MM_MUL)
                begin
                    started_reg <= 1'b1;
                end
            end
            else if (mm_busy_reg)
            begin
                mm_cnt_reg <= mm_cnt_reg + 1'b1;
                if (mm_cnt_reg == MM_LAST)
                begin
                    mm_busy_reg <= 1'b0;
                end
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg    <= char_in;
            invalid_reg <= inv_in;
            exp_reg     <= exp_wide[EXP_BITS-1:0];
            cnt_reg     <= CNT_LAST;
            acc_reg     <= 8'd1;
            base_reg    <= v_in;
        end
        if (cmd.advance)
        begin
            exp_reg <= exp_reg << 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.mm_start)
        begin
            mm_x_reg  <= '0;
            mm_op_reg <= cmd.mm_op;
            case (cmd.mm_op)
                MM_BASE:
                begin
                    mm_a_reg <= 8'd1;
                    mm_b_reg <= base_reg;
                end
                MM_SQR:
                begin
                    mm_a_reg <= acc_reg;
                    mm_b_reg <= acc_reg;
                end
                MM_MUL:
                begin
                    mm_a_reg <= base_reg;
                    mm_b_reg <= acc_reg;
                end
                default:
                begin
                    mm_a_reg <= acc_reg;
                    mm_b_reg <= acc_reg;
                end
            endcase
        end
        else if (mm_busy_reg)
        begin
            mm_x_reg <= mm_res;
            mm_b_reg <= mm_b_reg << 2;
            if (mm_cnt_reg == MM_LAST)
            begin
                if (mm_op_reg == MM_BASE)
                begin
                    base_reg <= mm_res;
                end
                else
                begin
                    acc_reg <= mm_res;
                end
            end
        end
        if (cmd.publish)
        begin
            char_out_reg    <= char_out_next;
            invalid_out_reg <= invalid_reg;
        end
    end

    assign sts.mm_busy  = mm_busy_reg;
    assign sts.exp_bit  = exp_reg[EXP_BITS-1];
    assign sts.bit_last = (cnt_reg == '0);
    assign sts.started  = started_reg;
    assign sts.invalid  = invalid_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign invalid   = invalid_out_reg;

endmodule

// File: hw/rtl/rsa_char_modexp_cipher_top.sv
// Character cipher by modular exponentiation, one character item at a time.
// Input channel: in_valid/in_ready with mode (0 encrypt, 1 decrypt) and char_in.
// Output channel: out_valid/out_ready with char_out and the invalid flag.
// Space maps to 0 and bytes from 64 up to b-64; the value is raised to the
// selected exponent mod the modulus and mapped back. Other bytes below 64
// come back unchanged with invalid set.
// Config: APB registers modulus (0x0), encrypt exponent (0x4), decrypt
// exponent (0x8); write only while no item is in flight.
// One item at a time through a shared base-4 modular multiplier; each
// multiply runs 4 digit steps while the controller waits for it to finish.
// From acceptance to out_valid: a base reduction, then every exponent bit
// from the top, with a squaring after the top set bit and a multiply per
// set bit, then the result is published to the output register.
// The next item can be taken in the same cycle that the result appears.
// An invalid byte skips the multiplier and goes from the base state
// straight to the finish.
// The result sits in an output register; a new item is taken while it waits,
// and a stalled receiver holds up only the finish of that next item.
// Reset restores modulus 35 and both exponents 5 and empties the block.
module rsa_char_modexp_cipher_top #(
    parameter int EXP_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rcm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rcm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rcm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [rcm_pkg::DATA_W-1:0]         char_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rcm_pkg::DATA_W-1:0]         char_out,
    output logic                               invalid
);
    import rcm_pkg::*;

    logic [DATA_W-1:0] modulus_reg;
    logic [EXP_W-1:0]  enc_exp_reg;
    logic [EXP_W-1:0]  dec_exp_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;
    cmd_t              cmd;
    sts_t              sts;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            enc_exp_reg <= EXP_RESET;
            dec_exp_reg <= EXP_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_MODULUS: modulus_reg <= pwdata[DATA_W-1:0];
                REG_ENC_EXP: enc_exp_reg <= pwdata[EXP_W-1:0];
                REG_DEC_EXP: dec_exp_reg <= pwdata[EXP_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODULUS: prdata = {{(APB_DATA_W-DATA_W){1'b0}}, modulus_reg};
            REG_ENC_EXP: prdata = {{(APB_DATA_W-EXP_W){1'b0}}, enc_exp_reg};
            REG_DEC_EXP: prdata = {{(APB_DATA_W-EXP_W){1'b0}}, dec_exp_reg};
            default:     prdata = '0;
        endcase
    end

    rcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rcm_datapath #(
        .EXP_BITS (EXP_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .mode             (mode),
        .char_in          (char_in),
        .modulus          (modulus_reg),
        .encrypt_exponent (enc_exp_reg),
        .decrypt_exponent (dec_exp_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .char_out         (char_out),
        .invalid          (invalid)
    );

endmodule

// File: hw/rtl/rcm_checker.sv
module rcm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rcm_pkg::DATA_W-1:0] char_out,
    input logic                       invalid
);
    import rcm_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(invalid))
        else $error("result changed while stalled");

    // a flagged item carries a byte below 64 that is not a space
    a_invalid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> (char_out < CHAR_OFFSET) && (char_out != CHAR_SPACE))
        else $error("invalid flag on a byte that maps");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // no result can follow an accepted item in the very next cycle unless one was already held
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind rsa_char_modexp_cipher_top rcm_checker u_rcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_out  (char_out),
    .invalid   (invalid)
);

// File: test/rsa_char_checker.sv
module rsa_char_checker #(
    parameter int EXP_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcm_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           mode,
    input  logic [rcm_pkg::DATA_W-1:0]     char_in,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [rcm_pkg::DATA_W-1:0]     char_out,
    input  logic                           invalid,
    output int                             fail_count,
    output int                             pending
);
    import rcm_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] ch;
        logic              bad;
    } cipher_res_t;

    cipher_res_t       cipher_q[$];
    logic [DATA_W-1:0] modulus_cp = MODULUS_RESET;
    logic [EXP_W-1:0]  enc_exp_cp = EXP_RESET;
    logic [EXP_W-1:0]  dec_exp_cp = EXP_RESET;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // modulus below two reduces everything to zero
    function automatic logic [31:0] mod_n(input logic [31:0] x, input logic [31:0] n);
        return (n < 32'd2) ? 32'd0 : x % n;
    endfunction

    function automatic cipher_res_t cipher_char(input logic m, input logic [DATA_W-1:0] c);
        cipher_res_t res;
        logic [31:0] n;
        logic [31:0] e;
        logic [31:0] acc;
        logic [31:0] b;
        int          top_bit;
        int          i;
        if (c < CHAR_OFFSET && c != CHAR_SPACE)
        begin
            res.ch  = c;
            res.bad = 1'b1;
            return res;
        end
        n       = {24'd0, modulus_cp};
        e       = {16'd0, m ? dec_exp_cp : enc_exp_cp};
        acc     = mod_n(32'd1, n);
        b       = mod_n((c == CHAR_SPACE) ? 32'd0 : {24'd0, c} - 32'd64, n);
        top_bit = (EXP_BITS > 32) ? 31 : EXP_BITS - 1;
        for (i = top_bit; i >= 0; i--)
        begin
            acc = mod_n(acc * acc, n);
            if (e[i])
                acc = mod_n(acc * b, n);
        end
        res.bad = 1'b0;
        res.ch  = (acc == 32'd0) ? CHAR_SPACE : DATA_W'(acc + 32'd64);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cipher_res_t want;
        if (!rst_n)
        begin
            modulus_cp = MODULUS_RESET;
            enc_exp_cp = EXP_RESET;
            dec_exp_cp = EXP_RESET;
            cipher_q.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_MODULUS: modulus_cp = pwdata[DATA_W-1:0];
                    REG_ENC_EXP: enc_exp_cp = pwdata[EXP_W-1:0];
                    REG_DEC_EXP: dec_exp_cp = pwdata[EXP_W-1:0];
                    default: ;
                endcase
            end
            // an item finishing never leaves in the edge it was taken, so pop first
            if (out_valid && out_ready)
            begin
                if (cipher_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected item char_out %02h invalid %0b",
                             $time, char_out, invalid);
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (char_out !== want.ch)
                    begin
                        fail_count++;
                        $display("%0t: char_out expected %02h actual %02h",
                                 $time, want.ch, char_out);
                    end
                    if (invalid !== want.bad)
                    begin
                        fail_count++;
                        $display("%0t: invalid expected %0b actual %0b",
                                 $time, want.bad, invalid);
                    end
                end
            end
            if (in_valid && in_ready)
                cipher_q.push_back(cipher_char(mode, char_in));
            pending = cipher_q.size();
        end
    end

endmodule

// File: test/tb_rsa_char_modexp_cipher_top.sv
module tb_rsa_char_modexp_cipher_top;
    import rcm_pkg::*;

    localparam int EXP_BITS   = 16;
    localparam int CYCLE_MAX  = 1000000;
    localparam int RAND_ITEMS = 800;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic [DATA_W-1:0]     char_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [DATA_W-1:0]     char_out;
    logic                  invalid;

    int fail_count;
    int pending;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;

    // typical two-prime moduli that keep results within a byte
    int rsa_moduli[] = '{6, 10, 14, 15, 21, 22, 33, 35, 39, 51, 55, 65, 77, 85, 91,
                         95, 115, 119, 133, 143, 161, 187};

    rsa_char_modexp_cipher_top #(
        .EXP_BITS (EXP_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .invalid   (invalid)
    );

    rsa_char_checker #(
        .EXP_BITS (EXP_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .char_in    (char_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_out   (char_out),
        .invalid    (invalid),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_MAX)
        begin
            $display("tb_rsa_char_modexp_cipher_top NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // registers only change once every item in flight has left
    task automatic set_key(input int n, input int e, input int d);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        apb_write(REG_MODULUS, n);
        apb_write(REG_ENC_EXP, e);
        apb_write(REG_DEC_EXP, d);
        // index three is unmapped; the write must leave the key alone
        apb_write(reg_idx_t'(2'd3), $urandom);
    endtask

    task automatic send_char(input logic m, input logic [DATA_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        char_in  <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic int rand_exponent();
        case ($urandom_range(5))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(1, 20);
            default: return $urandom_range(65535);
        endcase
    endfunction

    initial
    begin
        int n;
        int ch;
        cycles        = 0;
        send_idle_pct = 28;
        recv_idle_pct = 88;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        mode          = 1'b0;
        char_in       = '0;
        out_ready     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset key: space, bytes around the invalid boundary, base at the modulus
        send_char(1'b0, 8'h20);
        send_char(1'b1, 8'h20);
        send_char(1'b0, 8'h00);
        send_char(1'b1, 8'h1F);
        send_char(1'b0, 8'h21);
        send_char(1'b0, 8'h3F);
        send_char(1'b0, 8'h40);
        send_char(1'b1, 8'h41);
        send_char(1'b0, 8'h62);
        send_char(1'b1, 8'h63);
        send_char(1'b0, 8'h7F);
        send_char(1'b1, 8'hFF);
        send_char(1'b0, 8'h80);
        in_valid <= 1'b0;
        // zero exponent, base zero included
        set_key(35, 0, 65535);
        send_char(1'b0, 8'h40);
        send_char(1'b1, 8'h45);
        send_char(1'b0, 8'hFF);
        in_valid <= 1'b0;
        set_key(1, 3, 7);
        send_char(1'b0, 8'h50);
        send_char(1'b1, 8'h20);
        in_valid <= 1'b0;
        set_key(0, 1, 2);
        send_char(1'b0, 8'h41);
        in_valid <= 1'b0;
        // results above 191 wrap past 255
        set_key(255, 2, 65535);
        send_char(1'b0, 8'h4E);
        send_char(1'b1, 8'hFF);
        in_valid <= 1'b0;
        set_key(191, 1, 0);
        send_char(1'b0, 8'hFF);
        send_char(1'b0, 8'hFE);
        send_char(1'b1, 8'h7F);
        in_valid <= 1'b0;

        for (int k = 0; k < 8; k++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: n = rsa_moduli[$urandom_range(rsa_moduli.size() - 1)];
                4, 5:       n = $urandom_range(2, 191);
                6:          n = ($urandom_range(1)) ? 2 : 191;
                7:          n = $urandom_range(192, 255);
                8:          n = $urandom_range(1);
                default:    n = 255;
            endcase
            set_key(n, rand_exponent(), rand_exponent());
            for (int j = 0; j < RAND_ITEMS / 8; j++)
            begin
                if (k * (RAND_ITEMS / 8) + j < RAND_ITEMS / 3)
                begin
                    send_idle_pct = 28;
                    recv_idle_pct = 88;
                end
                else if (k * (RAND_ITEMS / 8) + j < 2 * RAND_ITEMS / 3)
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 28;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // mostly characters the cipher accepts, some arbitrary bytes
                case ($urandom_range(9))
                    0:       ch = 32;
                    1, 2:    ch = $urandom_range(255);
                    default: ch = $urandom_range(64, 255);
                endcase
                send_char(1'($urandom_range(1)), DATA_W'(ch));
            end
            in_valid <= 1'b0;
        end

        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_rsa_char_modexp_cipher_top OK");
        else
            $display("tb_rsa_char_modexp_cipher_top NOT OK");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rcm_pkg.sv
hw/rtl/rcm_ctrl.sv
hw/rtl/rcm_datapath.sv
hw/rtl/rsa_char_modexp_cipher_top.sv
hw/rtl/rcm_checker.sv
test/rsa_char_checker.sv
test/tb_rsa_char_modexp_cipher_top.sv
